>>> design/rat_pkg.sv
// rat_pkg: shared types and constants of the relay autotuner
// no dependencies; compiled first

package rat_pkg;

  localparam int DW = 32;
  localparam int FB = 16;

  // smallest relay step and tick period, 1e-4 and 1e-3 in q16.16, rounded up
  localparam logic [30:0] H_MIN  = 31'((((64'd1) << FB) + 64'd9999) / 64'd10000);
  localparam logic [31:0] DT_MIN = 32'((((64'd1) << FB) + 64'd999) / 64'd1000);

  // pi in q30, rounded
  localparam logic [31:0] PI_P = 32'hC90FDAA2;

  // ceil(2^34 / 5): floor(x * RECIP5 / 2^34) equals floor(x / 5) for any 32-bit x
  localparam logic [31:0] RECIP5       = 32'hCCCCCCCD;
  localparam int          RECIP5_SHIFT = 34;

  localparam int KU_SHIFT = 3 + FB + (62 - DW);
  localparam int KI_SHIFT = FB + 1;
  localparam int KD_SHIFT = FB + 3;
  localparam int DIV_N    = 80;
  localparam int CNT_W    = $clog2(DIV_N);

  typedef enum logic [2:0] {
    REG_SETPOINT   = 3'd0,
    REG_HYST       = 3'd1,
    REG_RELAY_AMP  = 3'd2,
    REG_MV_BIAS    = 3'd3,
    REG_REQ_CYCLES = 3'd4,
    REG_SETTLE     = 3'd5,
    REG_MAX_TICKS  = 3'd6,
    REG_TICK_PER   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KU_MUL,
    OP_KU_LD,
    OP_PU_MUL,
    OP_PU_LD,
    OP_KP_MUL,
    OP_KP_ST,
    OP_KI_LD,
    OP_KD_MUL,
    OP_KD_ST,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    DST_KU,
    DST_PU,
    DST_KI
  } dest_t;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_KU_MUL = 14'b00000000000010,
    S_KU_LD  = 14'b00000000000100,
    S_KU_DIV = 14'b00000000001000,
    S_PU_MUL = 14'b00000000010000,
    S_PU_LD  = 14'b00000000100000,
    S_PU_DIV = 14'b00000001000000,
    S_KP_MUL = 14'b00000010000000,
    S_KP_ST  = 14'b00000100000000,
    S_KI_LD  = 14'b00001000000000,
    S_KI_DIV = 14'b00010000000000,
    S_KD_MUL = 14'b00100000000000,
    S_KD_ST  = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic tick;
    op_t  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic latch_now;
    logic div_done;
  } sts_t;

endpackage

>>> design/rat_if.sv
// rat_if: valid/ready channel interfaces of the relay autotuner
// sample channel and result channel; no package needed

interface rat_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pv_sample;

  modport source (output valid, output pv_sample, input ready);
  modport sink   (input valid, input pv_sample, output ready);
endinterface

interface rat_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mv;
  logic               relay_on;
  logic               done_res;
  logic               ok;
  logic [7:0]         cycles;
  logic [31:0]        ku;
  logic [31:0]        pu;
  logic [31:0]        kp;
  logic [31:0]        ki;
  logic [31:0]        kd;
  logic [31:0]        amplitude;

  modport source (output valid, output mv, output relay_on, output done_res, output ok,
                  output cycles, output ku, output pu, output kp, output ki, output kd,
                  output amplitude, input ready);
  modport sink   (input valid, input mv, input relay_on, input done_res, input ok,
                  input cycles, input ku, input pu, input kp, input ki, input kd,
                  input amplitude, output ready);
endinterface

>>> design/rat_dp.sv
// rat_dp: autotuner datapath: config registers, relay and peak tracking,
// shared multiplier, shared restoring divider, result register; uses rat_pkg

module rat_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] pv_sample,
  input  rat_pkg::cmd_t      cmd,
  output rat_pkg::sts_t      sts,
  output logic signed [31:0] mv,
  output logic               relay_on,
  output logic               done_res,
  output logic               ok,
  output logic [7:0]         cycles,
  output logic [31:0]        ku,
  output logic [31:0]        pu,
  output logic [31:0]        kp,
  output logic [31:0]        ki,
  output logic [31:0]        kd,
  output logic [31:0]        amplitude
);
  import rat_pkg::*;

  // configuration
  logic signed [31:0] setpoint_r, bias_r;
  logic [30:0]        hyst_r, amp_r;
  logic [7:0]         req_r;
  logic [31:0]        settle_r, max_r, dt_r;

  // experiment state
  logic               relay_r, relay_nxt;
  logic               fin_r;
  logic [31:0]        tick_r, first_r, first_nxt, last_r, last_nxt;
  logic signed [31:0] high_r, high_nxt, low_r, low_nxt;
  logic [7:0]         upc_r, upc_nxt;

  // results
  logic [31:0]        ku_r, pu_r, kp_r, ki_r, kd_r, ampf_r;
  logic [63:0]        mul_r;
  logic [31:0]        mul_a, mul_b;

  // kp = floor(3 ku / 5) through the reciprocal of five
  logic [29:0]        kp_q;
  logic [31:0]        kp_rem_w, kp_new;
  logic [2:0]         kp_rem;
  logic [1:0]         kp_fix;

  // divider
  logic [DIV_N-1:0]   num_r;
  logic [63:0]        d_r, rem_r, rem_nxt;
  logic [31:0]        q_r, q_nxt, div_res;
  logic               sat_r, sat_nxt, ge;
  logic [64:0]        rem_w;
  logic [CNT_W-1:0]   cnt_r;
  dest_t              dest_r;

  // output register
  logic signed [31:0] mv_o_r;
  logic               relay_o_r, done_o_r, ok_o_r;
  logic [7:0]         cyc_o_r;
  logic [31:0]        ku_o_r, pu_o_r, kp_o_r, ki_o_r, kd_o_r, amp_o_r;

  logic signed [33:0] y_x, lo_th, hi_th, mv_w;
  logic signed [32:0] diff;
  logic [31:0]        amp_cur, lim, dt_eff;
  logic [30:0]        h;
  logic [7:0]         cyc_cur, cyc_nxt;
  logic               past, end_hit, ok_cur;
  logic signed [31:0] mv_sat;

  always_comb begin
    h      = (amp_r < H_MIN) ? H_MIN : amp_r;
    dt_eff = (dt_r < DT_MIN) ? DT_MIN : dt_r;
    lim    = (max_r == 32'd0) ? 32'd1 : max_r;
    y_x    = 34'(pv_sample);
    lo_th  = 34'(setpoint_r) - $signed({3'b000, hyst_r});
    hi_th  = 34'(setpoint_r) + $signed({3'b000, hyst_r});
    past   = tick_r > settle_r;
    diff   = 33'(high_r) - 33'(low_r);
    amp_cur = (diff < 33'sd1) ? 32'd1 : diff[31:0];
    cyc_cur = (upc_r == 8'd0) ? 8'd0 : upc_r - 8'd1;
    ok_cur  = fin_r && (cyc_cur >= 8'd2);

    high_nxt  = (past && pv_sample > high_r) ? pv_sample : high_r;
    low_nxt   = (past && pv_sample < low_r) ? pv_sample : low_r;
    relay_nxt = relay_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    upc_nxt   = upc_r;
    if (relay_r && y_x < lo_th) begin
      relay_nxt = 1'b0;
    end else if (!relay_r && y_x > hi_th) begin
      relay_nxt = 1'b1;
      if (past) begin
        if (upc_r == 8'd0) begin
          first_nxt = tick_r;
        end
        last_nxt = tick_r;
        if (upc_r != 8'hFF) begin
          upc_nxt = upc_r + 8'd1;
        end
      end
    end
    cyc_nxt = (upc_nxt == 8'd0) ? 8'd0 : upc_nxt - 8'd1;
    end_hit = (cyc_nxt >= req_r) || (({1'b0, tick_r} + 33'd1) >= {1'b0, lim});
    sts.latch_now = !fin_r && end_hit && (cyc_nxt >= 8'd2);
    sts.div_done  = (cnt_r == CNT_W'(DIV_N - 1));

    mv_w = relay_r ? (34'(bias_r) + $signed({3'b000, h}))
                   : (34'(bias_r) - $signed({3'b000, h}));
    if (mv_w > 34'sh07FFFFFFF) begin
      mv_sat = 32'sh7FFFFFFF;
    end else if (mv_w < -34'sh080000000) begin
      mv_sat = -32'sh80000000;
    end else begin
      mv_sat = mv_w[31:0];
    end

    case (cmd.op)
      OP_KU_MUL: begin mul_a = PI_P;              mul_b = amp_cur; end
      OP_PU_MUL: begin mul_a = last_r - first_r;  mul_b = dt_eff;  end
      OP_KP_MUL: begin mul_a = RECIP5;            mul_b = ku_r;    end
      default:   begin mul_a = kp_r;              mul_b = pu_r;    end
    endcase

    // ku = 5 q + rem, so 3 ku / 5 = 3 q + floor(3 rem / 5)
    kp_q     = mul_r[63:RECIP5_SHIFT];
    kp_rem_w = ku_r - (32'(kp_q) << 2) - 32'(kp_q);
    kp_rem   = kp_rem_w[2:0];
    kp_fix   = (kp_rem >= 3'd4) ? 2'd2 : ((kp_rem >= 3'd2) ? 2'd1 : 2'd0);
    kp_new   = (32'(kp_q) << 1) + 32'(kp_q) + 32'(kp_fix);

    rem_w   = {rem_r, num_r[DIV_N-1]};
    ge      = rem_w >= {1'b0, d_r};
    rem_nxt = ge ? 64'(rem_w - {1'b0, d_r}) : rem_w[63:0];
    q_nxt   = {q_r[30:0], ge};
    sat_nxt = sat_r | q_r[31];
    div_res = sat_nxt ? 32'hFFFFFFFF : q_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      hyst_r     <= '0;
      amp_r      <= 31'(1 << FB);
      bias_r     <= '0;
      req_r      <= 8'd4;
      settle_r   <= 32'd50;
      max_r      <= 32'd100000;
      dt_r       <= 32'(1 << FB);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SETPOINT:   setpoint_r <= cfg_data;
        REG_HYST:       hyst_r     <= cfg_data[30:0];
        REG_RELAY_AMP:  amp_r      <= cfg_data[30:0];
        REG_MV_BIAS:    bias_r     <= cfg_data;
        REG_REQ_CYCLES: req_r      <= cfg_data[7:0];
        REG_SETTLE:     settle_r   <= cfg_data;
        REG_MAX_TICKS:  max_r      <= cfg_data;
        REG_TICK_PER:   dt_r       <= cfg_data;
        default:        ;
      endcase
    end
  end

  // per-sample state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r <= 1'b1;
      fin_r   <= 1'b0;
      tick_r  <= '0;
      high_r  <= -32'sh80000000;
      low_r   <= 32'sh7FFFFFFF;
      upc_r   <= '0;
      first_r <= '0;
      last_r  <= '0;
    end else if (cmd.tick && !fin_r) begin
      relay_r <= relay_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
      upc_r   <= upc_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      if (tick_r != 32'hFFFFFFFF) begin
        tick_r <= tick_r + 32'd1;
      end
      if (end_hit) begin
        fin_r <= 1'b1;
      end
    end
  end

  // multiplier, divider and result latches
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_KU_MUL, OP_PU_MUL, OP_KP_MUL, OP_KD_MUL: mul_r <= mul_a * mul_b;
      default: ;
    endcase
    case (cmd.op)
      OP_KU_MUL: ampf_r <= amp_cur;
      OP_KU_LD: begin
        num_r  <= DIV_N'(h) << KU_SHIFT;
        d_r    <= mul_r;
        dest_r <= DST_KU;
      end
      OP_PU_LD: begin
        num_r  <= DIV_N'(mul_r);
        d_r    <= 64'(cyc_cur);
        dest_r <= DST_PU;
      end
      OP_KP_ST: kp_r <= kp_new;
      OP_KI_LD: begin
        num_r  <= DIV_N'(kp_r) << KI_SHIFT;
        d_r    <= 64'(pu_r);
        dest_r <= DST_KI;
      end
      OP_KD_ST: kd_r <= (|mul_r[63:KD_SHIFT+32]) ? 32'hFFFFFFFF : mul_r[KD_SHIFT+31:KD_SHIFT];
      OP_DIV: begin
        num_r <= num_r << 1;
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        sat_r <= sat_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        if (sts.div_done) begin
          case (dest_r)
            DST_KU:  ku_r <= div_res;
            DST_PU:  pu_r <= div_res;
            default: ki_r <= (pu_r == 32'd0) ? 32'd0 : div_res;
          endcase
        end
      end
      default: ;
    endcase
    if (cmd.op == OP_KU_LD || cmd.op == OP_PU_LD || cmd.op == OP_KI_LD) begin
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
      cnt_r <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mv_o_r    <= mv_sat;
      relay_o_r <= relay_r;
      done_o_r  <= fin_r;
      ok_o_r    <= ok_cur;
      cyc_o_r   <= cyc_cur;
      ku_o_r    <= ok_cur ? ku_r : 32'd0;
      pu_o_r    <= ok_cur ? pu_r : 32'd0;
      kp_o_r    <= ok_cur ? kp_r : 32'd0;
      ki_o_r    <= ok_cur ? ki_r : 32'd0;
      kd_o_r    <= ok_cur ? kd_r : 32'd0;
      amp_o_r   <= ok_cur ? ampf_r : amp_cur;
    end
  end

  assign mv        = mv_o_r;
  assign relay_on  = relay_o_r;
  assign done_res  = done_o_r;
  assign ok        = ok_o_r;
  assign cycles    = cyc_o_r;
  assign ku        = ku_o_r;
  assign pu        = pu_o_r;
  assign kp        = kp_o_r;
  assign ki        = ki_o_r;
  assign kd        = kd_o_r;
  assign amplitude = amp_o_r;

endmodule

>>> design/rat_ctrl.sv
// rat_ctrl: sequencer of the relay autotuner and result valid flag
// drives rat_dp through cmd_t, reads sts_t; uses rat_pkg

module rat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rat_pkg::sts_t sts,
  output rat_pkg::cmd_t cmd
);
  import rat_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd.tick     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.tick  = 1'b1;
          state_nxt = sts.latch_now ? S_KU_MUL : S_OUT;
        end
      end
      S_KU_MUL: begin cmd.op = OP_KU_MUL; state_nxt = S_KU_LD; end
      S_KU_LD:  begin cmd.op = OP_KU_LD;  state_nxt = S_KU_DIV; end
      S_KU_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_done) state_nxt = S_PU_MUL;
      end
      S_PU_MUL: begin cmd.op = OP_PU_MUL; state_nxt = S_PU_LD; end
      S_PU_LD:  begin cmd.op = OP_PU_LD;  state_nxt = S_PU_DIV; end
      S_PU_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_done) state_nxt = S_KP_MUL;
      end
      S_KP_MUL: begin cmd.op = OP_KP_MUL; state_nxt = S_KP_ST; end
      S_KP_ST:  begin cmd.op = OP_KP_ST;  state_nxt = S_KI_LD; end
      S_KI_LD:  begin cmd.op = OP_KI_LD;  state_nxt = S_KI_DIV; end
      S_KI_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_done) state_nxt = S_KD_MUL;
      end
      S_KD_MUL: begin cmd.op = OP_KD_MUL; state_nxt = S_KD_ST; end
      S_KD_ST:  begin cmd.op = OP_KD_ST;  state_nxt = S_OUT; end
      S_OUT: begin
        cmd.load_out = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE) else $error("accept did not leave idle");
  a_plain_tick_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !sts.latch_now |=> state_r == S_OUT) else $error("plain tick skipped output");
  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT)) else $error("result raised outside output");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> !out_valid_r) else $error("result slot still full");

endmodule

>>> design/relay_autotune_zn.sv
// relay_autotune_zn: top level of the relay-feedback autotuner
// instantiates rat_ctrl and rat_dp; uses rat_pkg and rat_if
//
//  channel  | direction | payload
//  in_ch    | sink      | pv_sample, one process sample per tick
//  out_ch   | source    | mv, relay_on, done_res, ok, cycles, ku, pu, kp, ki, kd, amplitude
//  cfg_*    | write     | 3-bit register index, 32-bit data, no read-back
//
// an ordinary sample is updated at accept, then its result is loaded in the output state
// the sample that ends the experiment with two or more cycles also runs the gain arithmetic:
//   three 80-step passes of the one shared restoring divider plus multiplies
// the next sample is taken once the block is back in idle and the result slot is free
// or being emptied, so a stalled result holds at most one transaction
// reset is synchronous, active low; it sets config, per-sample state and sequencer, not the result registers

module relay_autotune_zn (
  input  logic        clk,
  input  logic        rst_n,
  rat_in_if.sink      in_ch,
  rat_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: handshakes and step order
  rat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: relay, peaks, crossings, gain arithmetic, result register
  rat_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pv_sample (in_ch.pv_sample),
    .cmd       (cmd),
    .sts       (sts),
    .mv        (out_ch.mv),
    .relay_on  (out_ch.relay_on),
    .done_res  (out_ch.done_res),
    .ok        (out_ch.ok),
    .cycles    (out_ch.cycles),
    .ku        (out_ch.ku),
    .pu        (out_ch.pu),
    .kp        (out_ch.kp),
    .ki        (out_ch.ki),
    .kd        (out_ch.kd),
    .amplitude (out_ch.amplitude)
  );

endmodule
